/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

/* src/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types for the free list allocator: request codes, controller
// states and the command and status words between controller and datapath
// ----------------------------------------------------------------------------
package fpa_pkg;

	// request codes carried by the action field
	typedef enum logic [1:0] {
		ACT_ALLOC      = 2'd0,
		ACT_ALLOC_NEXT = 2'd1,
		ACT_FREE       = 2'd2,
		ACT_CLEAR      = 2'd3
	} action_t;

	// controller states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_RD,
		ST_A_WB,
		ST_F_RD,
		ST_F_WB,
		ST_CLR,
		ST_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic init_wr;     // clearing pass: write one link word
		logic load_req;    // capture request word
		logic alloc_rd;    // read link of the head entry
		logic alloc_wb;    // pop head, write new link of popped entry
		logic link_given;  // popped entry links to the given entry
		logic reject;      // empty pool: count call and rejection
		logic free_rd;     // read link of current chain entry
		logic free_wb;     // push current chain entry on the free list
		logic clr_stats;   // zero the counters
		logic load_out;    // load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic init_last;     // clearing pass is at its last entry
		logic head_present;  // free list not empty
		logic chain_go;      // chain entry present and step bound not reached
		logic out_free;      // result register can take a word
	} status_t;

endpackage

/* src/fixed_pool_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// fixed_pool_free_list_allocator_top
// lifo free list allocator over a pool of fixed entries
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every pool entry that
// builds the initial free list in the link memory; in_ready stays low until
// it is done. Requests are handled one at a time. Allocate steps from
// acceptance to the result word being loaded through accept, head read, link
// write and result load, set by the registered read of the single-port-pair
// link memory; a refused allocate has no link write. Clear statistics runs
// accept, clear and result load. Free chain walks the chain entry by entry,
// and each step of the walk is a memory read followed by a write;
// allocate-with-next on an empty pool walks the given chain after the
// refused head read. A new request can be taken while the previous result
// word still waits on the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_pool_free_list_allocator_top #(
	parameter int POOL_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  entry_index,
	input  logic        entry_present,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  granted_index,
	output logic        granted,
	output logic [8:0]  free_count,
	output logic [31:0] allocate_calls,
	output logic [31:0] rejected_calls
);

	fpa_pkg::cmd_t    cmd;
	fpa_pkg::status_t status;
	fpa_pkg::state_t  state;

	// request sequencer
	fpa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action  (action),
		.status  (status),
		.cmd     (cmd),
		.state   (state)
	);

	// link memory and counters
	fpa_dp #(
		.POOL_ENTRIES(POOL_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.entry_index   (entry_index),
		.entry_present (entry_present),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.granted_index (granted_index),
		.granted       (granted),
		.free_count    (free_count),
		.allocate_calls(allocate_calls),
		.rejected_calls(rejected_calls)
	);

	// link memory write sources never collide
	`ASSERT_ALWAYS(a_one_writer, $onehot0({cmd.init_wr, cmd.alloc_wb, cmd.free_wb}), "writers overlap")
	// every pop uses data read in the previous cycle
	`ASSERT_IMPL(a_pop_after_read, cmd.alloc_wb, $past(cmd.alloc_rd), "pop without head read")
	// every push uses data read in the previous cycle
	`ASSERT_IMPL(a_push_after_read, cmd.free_wb, $past(cmd.free_rd), "push without chain read")
	// a new result word appears only after a result load
	`ASSERT_IMPL(a_out_from_load, $rose(out_valid), $past(cmd.load_out), "word without load")
	// no request is taken during the clearing pass
	`ASSERT_IMPL(a_no_accept_in_init, state == fpa_pkg::ST_INIT, !in_ready, "ready during init")

endmodule

/* src/fpa_ram.sv */
// ----------------------------------------------------------------------------
// fpa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fpa_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/fpa_ctrl.sv */
// ----------------------------------------------------------------------------
// fpa_ctrl
// request sequencer: clearing pass, allocate read-modify-write, chain walk,
// statistics clear and result hand-off
// ----------------------------------------------------------------------------
module fpa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       action,
	input  fpa_pkg::status_t status,
	output fpa_pkg::cmd_t    cmd,
	output fpa_pkg::state_t  state
);

	fpa_pkg::state_t  state_q;
	fpa_pkg::state_t  state_nxt;
	fpa_pkg::action_t act_q;
	fpa_pkg::action_t act_in;

	assign act_in = fpa_pkg::action_t'(action);
	assign state  = state_q;

	// state and captured request code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpa_pkg::ST_INIT;
			act_q   <= fpa_pkg::ACT_ALLOC;
		end else begin
			state_q <= state_nxt;
			if (in_valid && in_ready) begin
				act_q <= act_in;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fpa_pkg::ST_INIT: begin
				if (status.init_last) state_nxt = fpa_pkg::ST_IDLE;
			end
			fpa_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (act_in)
						fpa_pkg::ACT_ALLOC,
						fpa_pkg::ACT_ALLOC_NEXT: state_nxt = fpa_pkg::ST_A_RD;
						fpa_pkg::ACT_FREE:       state_nxt = fpa_pkg::ST_F_RD;
						fpa_pkg::ACT_CLEAR:      state_nxt = fpa_pkg::ST_CLR;
					endcase
				end
			end
			fpa_pkg::ST_A_RD: begin
				priority if (status.head_present) begin
					state_nxt = fpa_pkg::ST_A_WB;
				end else if (act_q == fpa_pkg::ACT_ALLOC_NEXT) begin
					state_nxt = fpa_pkg::ST_F_RD;
				end else begin
					state_nxt = fpa_pkg::ST_FIN;
				end
			end
			fpa_pkg::ST_A_WB: state_nxt = fpa_pkg::ST_FIN;
			fpa_pkg::ST_F_RD: begin
				state_nxt = status.chain_go ? fpa_pkg::ST_F_WB : fpa_pkg::ST_FIN;
			end
			fpa_pkg::ST_F_WB: state_nxt = fpa_pkg::ST_F_RD;
			fpa_pkg::ST_CLR:  state_nxt = fpa_pkg::ST_FIN;
			fpa_pkg::ST_FIN: begin
				if (status.out_free) state_nxt = fpa_pkg::ST_IDLE;
			end
			default: state_nxt = fpa_pkg::ST_INIT;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			fpa_pkg::ST_INIT: cmd.init_wr = 1'b1;
			fpa_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
			end
			fpa_pkg::ST_A_RD: begin
				cmd.alloc_rd = status.head_present;
				cmd.reject   = !status.head_present;
			end
			fpa_pkg::ST_A_WB: begin
				cmd.alloc_wb   = 1'b1;
				cmd.link_given = (act_q == fpa_pkg::ACT_ALLOC_NEXT);
			end
			fpa_pkg::ST_F_RD: cmd.free_rd   = status.chain_go;
			fpa_pkg::ST_F_WB: cmd.free_wb   = 1'b1;
			fpa_pkg::ST_CLR:  cmd.clr_stats = 1'b1;
			fpa_pkg::ST_FIN:  cmd.load_out  = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

/* src/fpa_dp.sv */
// ----------------------------------------------------------------------------
// fpa_dp
// datapath: link memory, free list head, free count, call counters,
// chain walk registers and the result register
// ----------------------------------------------------------------------------
module fpa_dp #(
	parameter int POOL_ENTRIES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fpa_pkg::cmd_t    cmd,
	output fpa_pkg::status_t status,
	input  logic [7:0]       entry_index,
	input  logic             entry_present,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [7:0]       granted_index,
	output logic             granted,
	output logic [8:0]       free_count,
	output logic [31:0]      allocate_calls,
	output logic [31:0]      rejected_calls
);

	localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int TW = $clog2(POOL_ENTRIES + 1);
	localparam int LW = IW + 1;

	// link word: present bit over entry index
	logic [LW-1:0] head_q;
	logic [LW-1:0] chain_q;
	logic [LW-1:0] given_q;
	logic [LW-1:0] grant_q;
	logic [TW-1:0] total_q;
	logic [TW-1:0] steps_q;
	logic [IW-1:0] init_cnt_q;
	logic [31:0]   calls_q;
	logic [31:0]   rejects_q;

	logic [31:0]   entry_ext;
	logic [LW-1:0] given_link;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [LW-1:0] mem_wdata;
	logic [IW-1:0] mem_raddr;
	logic [LW-1:0] mem_rdata;
	logic [31:0]   grant_ext;
	logic [31:0]   total_ext;

	// given entry: null when absent or out of the pool
	assign entry_ext  = {24'd0, entry_index};
	assign given_link = (entry_present && (entry_ext < 32'(POOL_ENTRIES)))
		? {1'b1, entry_ext[IW-1:0]} : '0;

	// memory write source select
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = init_cnt_q;
		mem_wdata = '0;
		priority if (cmd.init_wr) begin
			mem_we    = 1'b1;
			mem_waddr = init_cnt_q;
			mem_wdata = (init_cnt_q == '0) ? '0 : {1'b1, init_cnt_q - IW'(1)};
		end else if (cmd.alloc_wb) begin
			mem_we    = 1'b1;
			mem_waddr = head_q[IW-1:0];
			mem_wdata = cmd.link_given ? given_q : '0;
		end else if (cmd.free_wb) begin
			mem_we    = 1'b1;
			mem_waddr = chain_q[IW-1:0];
			mem_wdata = head_q;
		end else begin
			mem_we = 1'b0;
		end
	end

	assign mem_raddr = cmd.alloc_rd ? head_q[IW-1:0] : chain_q[IW-1:0];

	fpa_ram #(
		.WIDTH(LW),
		.DEPTH(POOL_ENTRIES)
	) u_link_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// free list state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= {1'b1, IW'(POOL_ENTRIES - 1)};
			total_q    <= TW'(POOL_ENTRIES);
			init_cnt_q <= '0;
			calls_q    <= '0;
			rejects_q  <= '0;
			chain_q    <= '0;
			given_q    <= '0;
			grant_q    <= '0;
			steps_q    <= '0;
		end else begin
			if (cmd.init_wr) begin
				init_cnt_q <= init_cnt_q + IW'(1);
			end
			if (cmd.load_req) begin
				chain_q <= given_link;
				given_q <= given_link;
				grant_q <= '0;
				steps_q <= '0;
			end
			// pop the head entry
			if (cmd.alloc_wb) begin
				grant_q <= head_q;
				head_q  <= mem_rdata;
				calls_q <= calls_q + 32'd1;
				if (total_q != '0) total_q <= total_q - TW'(1);
			end
			if (cmd.reject) begin
				calls_q   <= calls_q + 32'd1;
				rejects_q <= rejects_q + 32'd1;
			end
			// push one chain entry, follow its old link
			if (cmd.free_wb) begin
				chain_q <= mem_rdata;
				head_q  <= {1'b1, chain_q[IW-1:0]};
				steps_q <= steps_q + TW'(1);
				if (total_q < TW'(POOL_ENTRIES)) total_q <= total_q + TW'(1);
			end
			if (cmd.clr_stats) begin
				calls_q   <= '0;
				rejects_q <= '0;
			end
		end
	end

	// result register
	assign grant_ext = 32'(grant_q[IW-1:0]);
	assign total_ext = 32'(total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			granted_index  <= grant_q[LW-1] ? grant_ext[7:0] : 8'd0;
			granted        <= grant_q[LW-1];
			free_count     <= total_ext[8:0];
			allocate_calls <= calls_q;
			rejected_calls <= rejects_q;
		end
	end

	// status to controller
	assign status.init_last    = (init_cnt_q == IW'(POOL_ENTRIES - 1));
	assign status.head_present = head_q[LW-1];
	assign status.chain_go     = chain_q[LW-1] && (steps_q < TW'(POOL_ENTRIES));
	assign status.out_free     = !out_valid || out_ready;

endmodule
